>>> sv/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg
// shared constants, types and byte checks for the radar report frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package rrfp_pkg;

    localparam int FRAME_BYTES  = 23;
    localparam int COUNT_W      = 5;
    localparam int RX_DATA_W    = 8;
    localparam int REPORT_W     = 67;
    localparam int REPORT_TDATA_W = 72;

    localparam logic [7:0] HEAD_0 = 8'hF4;
    localparam logic [7:0] HEAD_1 = 8'hF3;
    localparam logic [7:0] HEAD_2 = 8'hF2;
    localparam logic [7:0] HEAD_3 = 8'hF1;
    localparam logic [7:0] TAIL_0 = 8'hF8;
    localparam logic [7:0] TAIL_1 = 8'hF7;
    localparam logic [7:0] TAIL_2 = 8'hF6;
    localparam logic [7:0] TAIL_3 = 8'hF5;
    localparam logic [7:0] PAYLOAD_LEN_LO = 8'd13;
    localparam logic [7:0] PAYLOAD_LEN_HI = 8'd0;
    localparam logic [7:0] MARK_0   = 8'h02;
    localparam logic [7:0] MARK_1   = 8'hAA;
    localparam logic [7:0] MARK_END = 8'h55;

    localparam logic [2:0] STATE_UNKNOWN = 3'd4;
    localparam logic [7:0] STATE_MAX_RAW = 8'd3;

    localparam logic [COUNT_W-1:0] POS_HUNT      = 5'd0;
    localparam logic [COUNT_W-1:0] POS_HEAD_END  = 5'd3;
    localparam logic [COUNT_W-1:0] POS_LEN_LO    = 5'd4;
    localparam logic [COUNT_W-1:0] POS_LEN_HI    = 5'd5;
    localparam logic [COUNT_W-1:0] POS_MARK_0    = 5'd6;
    localparam logic [COUNT_W-1:0] POS_MARK_1    = 5'd7;
    localparam logic [COUNT_W-1:0] POS_STATE     = 5'd8;
    localparam logic [COUNT_W-1:0] POS_MDIST_LO  = 5'd9;
    localparam logic [COUNT_W-1:0] POS_MDIST_HI  = 5'd10;
    localparam logic [COUNT_W-1:0] POS_MENERGY   = 5'd11;
    localparam logic [COUNT_W-1:0] POS_SDIST_LO  = 5'd12;
    localparam logic [COUNT_W-1:0] POS_SDIST_HI  = 5'd13;
    localparam logic [COUNT_W-1:0] POS_SENERGY   = 5'd14;
    localparam logic [COUNT_W-1:0] POS_DDIST_LO  = 5'd15;
    localparam logic [COUNT_W-1:0] POS_DDIST_HI  = 5'd16;
    localparam logic [COUNT_W-1:0] POS_MARK_END  = 5'd17;
    localparam logic [COUNT_W-1:0] POS_TAIL_0    = 5'd19;
    localparam logic [COUNT_W-1:0] POS_TAIL_1    = 5'd20;
    localparam logic [COUNT_W-1:0] POS_TAIL_2    = 5'd21;
    localparam logic [COUNT_W-1:0] POS_LAST      = 5'(FRAME_BYTES - 1);
    localparam logic [COUNT_W-1:0] POS_FRAME_END = 5'(FRAME_BYTES);

    typedef struct packed {
        logic [2:0]  target_state;
        logic [15:0] mov_dist;
        logic [7:0]  mov_level;
        logic [15:0] stat_dist;
        logic [7:0]  stat_level;
        logic [15:0] det_dist;
    } report_t;

    typedef struct packed {
        logic    valid;
        report_t report;
    } report_word_t;

    function automatic logic [7:0] head_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = HEAD_0;
            2'd1:    val = HEAD_1;
            2'd2:    val = HEAD_2;
            default: val = HEAD_3;
        endcase
        return val;
    endfunction

    // fixed-value bytes of the frame body; unchecked positions pass
    function automatic logic body_byte_ok(input logic [COUNT_W-1:0] pos,
                                          input logic [7:0] rx);
        logic ok;
        case (pos)
            POS_LEN_LO:   ok = (rx == PAYLOAD_LEN_LO);
            POS_LEN_HI:   ok = (rx == PAYLOAD_LEN_HI);
            POS_MARK_0:   ok = (rx == MARK_0);
            POS_MARK_1:   ok = (rx == MARK_1);
            POS_MARK_END: ok = (rx == MARK_END);
            POS_TAIL_0:   ok = (rx == TAIL_0);
            POS_TAIL_1:   ok = (rx == TAIL_1);
            POS_TAIL_2:   ok = (rx == TAIL_2);
            POS_LAST:     ok = (rx == TAIL_3);
            default:      ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> sv/rrfp_frame_parser.sv
// ----------------------------------------------------------------------------
// rrfp_frame_parser
// input byte register, header hunt, frame checks and field capture
// ----------------------------------------------------------------------------
`default_nettype none

module rrfp_frame_parser
    import rrfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [RX_DATA_W-1:0] s_tdata,    // [7:0] rx_byte
    input  wire logic                 out_free,
    output report_word_t              rep_word
);

    logic                 in_valid_reg;
    logic [RX_DATA_W-1:0] in_byte_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 ok_reg, ok_next;
    report_t              fields_reg;
    logic                 advance;
    logic                 report_due;
    logic [RX_DATA_W-1:0] rx;

    // only a byte that completes a good frame waits for the result register
    assign report_due = (count_reg == POS_LAST) & ok_reg & body_byte_ok(count_reg, rx);
    assign advance    = in_valid_reg & (out_free | ~report_due);
    assign s_tready   = ~in_valid_reg | out_free | ~report_due;
    assign rx         = in_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        count_next = count_reg;
        ok_next    = ok_reg;
        if (count_reg == POS_HUNT) begin
            count_next = (rx == HEAD_0) ? 5'd1 : POS_HUNT;
        end else if (count_reg <= POS_HEAD_END) begin
            if (rx == head_byte(count_reg[1:0])) begin
                count_next = count_reg + 5'd1;
            end else begin
                count_next = (rx == HEAD_0) ? 5'd1 : POS_HUNT;
            end
        end else if (count_reg >= POS_FRAME_END) begin
            count_next = POS_HUNT;
        end else begin
            count_next = (count_reg == POS_LAST) ? POS_HUNT : count_reg + 5'd1;
            if (count_reg == POS_LEN_LO) begin
                ok_next = body_byte_ok(count_reg, rx);
            end else begin
                ok_next = ok_reg & body_byte_ok(count_reg, rx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= POS_HUNT;
            ok_reg    <= 1'b0;
        end else if (advance) begin
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            case (count_reg)
                POS_STATE:    fields_reg.target_state <=
                                  (rx <= STATE_MAX_RAW) ? rx[2:0] : STATE_UNKNOWN;
                POS_MDIST_LO: fields_reg.mov_dist[7:0]   <= rx;
                POS_MDIST_HI: fields_reg.mov_dist[15:8]  <= rx;
                POS_MENERGY:  fields_reg.mov_level       <= rx;
                POS_SDIST_LO: fields_reg.stat_dist[7:0]  <= rx;
                POS_SDIST_HI: fields_reg.stat_dist[15:8] <= rx;
                POS_SENERGY:  fields_reg.stat_level      <= rx;
                POS_DDIST_LO: fields_reg.det_dist[7:0]   <= rx;
                POS_DDIST_HI: fields_reg.det_dist[15:8]  <= rx;
                default: ;
            endcase
        end
    end

    assign rep_word.valid  = advance & report_due;
    assign rep_word.report = fields_reg;

endmodule

`default_nettype wire

>>> sv/rrfp_out_reg.sv
// ----------------------------------------------------------------------------
// rrfp_out_reg
// result register holding one report word until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module rrfp_out_reg
    import rrfp_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire report_word_t              rep_word,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [REPORT_TDATA_W-1:0]      m_tdata
);

    logic    m_tvalid_reg;
    report_t report_reg;

    assign out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rep_word.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (rep_word.valid) begin
            report_reg <= rep_word.report;
        end
    end

    assign m_tdata = {
        (REPORT_TDATA_W - REPORT_W)'(0),
        report_reg.det_dist,
        report_reg.stat_level,
        report_reg.stat_dist,
        report_reg.mov_level,
        report_reg.mov_dist,
        report_reg.target_state
    };

endmodule

`default_nettype wire

>>> sv/radar_report_frame_parser_core.sv
// ----------------------------------------------------------------------------
// radar_report_frame_parser_core
// parses 23-byte radar target report frames from a serial byte stream
// ----------------------------------------------------------------------------
// s_ channel: one received serial byte per word. the parser hunts for the
// header F4 F3 F2 F1, collects the rest of the frame and checks the length,
// markers and footer. m_ channel: one report word per valid frame, none for
// a frame that fails a check.
// m_tvalid rises once the last frame byte has passed the input register
// and then the result register.
// throughput: one byte per cycle while no due report waits on a busy result
// register; the parse step between the byte and result registers is combinational.
// reset: aresetn low returns the parser to header hunting and empties both
// registers; no report is pending afterwards.
// stall: a held report keeps its word; the next byte is still taken into
// the input register, and bytes flow on as long as no second report is due
// while the first waits.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_report_frame_parser_core
    import rrfp_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [RX_DATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [2:0] target state, [18:3] moving distance, [26:19] moving level,
    // [42:27] stationary distance, [50:43] stationary level,
    // [66:51] detection distance, [71:67] zero
    output logic [REPORT_TDATA_W-1:0]      m_tdata
);

    report_word_t rep_word;
    logic         out_free;

    rrfp_frame_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .rep_word (rep_word)
    );

    rrfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rep_word (rep_word),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
